// ----- design/rbsi_pkg.sv -----
// -----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants for the segment versus box slab test.
// -----------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

   localparam int FRAC_BITS_DEF = 16;   // parameter fraction bits (Q1.16)
   localparam int COORD_W       = 32;   // coordinate width, signed
   localparam int NUM_AXES      = 3;
   localparam int CSR_IDX_W     = 3;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Z = 3'd5;

endpackage

`default_nettype wire

// ----- design/rbsi_if.sv -----
// -----------------------------------------------------------------------------
// rbsi_if
// Channel interfaces: segment request, hit response, register write.
// -----------------------------------------------------------------------------
`default_nettype none

interface rbsi_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [31:0] delta_x;
   logic signed [31:0] delta_y;
   logic signed [31:0] delta_z;

   modport source (output valid, origin_x, origin_y, origin_z,
                   delta_x, delta_y, delta_z, input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z,
                   delta_x, delta_y, delta_z, output ready);
endinterface

interface rbsi_rsp_if #(parameter int FRAC_BITS = 16);
   logic               valid;
   logic               ready;
   logic               hit;
   logic [FRAC_BITS:0] entry_fraction;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;

   modport source (output valid, hit, entry_fraction, point_x, point_y, point_z,
                   input ready);
   modport sink   (input valid, hit, entry_fraction, point_x, point_y, point_z,
                   output ready);
endinterface

interface rbsi_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/rbsi_slab_div.sv -----
// -----------------------------------------------------------------------------
// rbsi_slab_div
// Pipelined restoring divider, one quotient bit per stage, result clamped
// to [-1 lsb, 1.0 + 1 lsb] which keeps every slab comparison intact.
// -----------------------------------------------------------------------------
`default_nettype none

module rbsi_slab_div import rbsi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [32:0]                num_mag,
   input  logic [31:0]                den_mag,
   input  logic                       neg,
   output logic signed [FRAC_BITS+2:0] quot
);

   localparam int NUM_W = 33 + FRAC_BITS;
   localparam int STEPS = FRAC_BITS + 2;
   localparam int Q_W   = FRAC_BITS + 3;
   localparam logic signed [Q_W-1:0] Q_TOP = Q_W'((1 << FRAC_BITS) + 1);

   logic [NUM_W-1:0] rem_ff [STEPS+1];
   logic [31:0]      den_ff [STEPS+1];
   logic [STEPS-1:0] qb_ff  [STEPS+1];
   logic [STEPS:0]   neg_ff;
   logic [STEPS:0]   sat_ff;
   logic signed [Q_W-1:0] quot_ff, quot_in;

   // load: quotient would need more than STEPS bits -> saturate
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {num_mag, FRAC_BITS'(0)};
         den_ff[0] <= den_mag;
         qb_ff[0]  <= '0;
         neg_ff[0] <= neg;
         sat_ff[0] <= ({1'b0, num_mag} >= {den_mag, 2'b00});
      end
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int K = STEPS - 1 - j;
      logic [NUM_W-1:0] trial;
      logic             ge;
      assign trial = NUM_W'(den_ff[j]) << K;
      assign ge    = (rem_ff[j] >= trial);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge ? (rem_ff[j] - trial) : rem_ff[j];
            den_ff[j+1] <= den_ff[j];
            qb_ff[j+1]  <= qb_ff[j] | (STEPS'(ge) << K);
            neg_ff[j+1] <= neg_ff[j];
            sat_ff[j+1] <= sat_ff[j];
         end
      end
   end

   always_comb begin
      if (sat_ff[STEPS]) begin
         quot_in = neg_ff[STEPS] ? '1 : Q_TOP;
      end else if (neg_ff[STEPS]) begin
         quot_in = (qb_ff[STEPS] == '0) ? '0 : '1;
      end else if ($signed({1'b0, qb_ff[STEPS]}) > Q_TOP) begin
         quot_in = Q_TOP;
      end else begin
         quot_in = $signed({1'b0, qb_ff[STEPS]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

// ----- design/rbsi_point.sv -----
// -----------------------------------------------------------------------------
// rbsi_point
// Entry point on one axis: origin + floor(delta * t), saturated to 32 bits.
// -----------------------------------------------------------------------------
`default_nettype none

module rbsi_point import rbsi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [31:0]  org,
   input  logic signed [31:0]  dlt,
   input  logic [FRAC_BITS:0]  lo,
   output logic signed [31:0]  pt
);

   localparam int PW = 34 + FRAC_BITS;
   localparam logic signed [34:0] PT_MAX = 35'sh0_7FFF_FFFF;
   localparam logic signed [34:0] PT_MIN = -35'sh0_8000_0000;

   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [31:0]   org_ff;
   logic signed [PW-1:0] shifted;
   logic signed [34:0]   sum;

   assign prod_in = PW'(dlt) * $signed(PW'({1'b0, lo}));

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         org_ff  <= org;
      end
   end

   // arithmetic shift is the floor
   assign shifted = prod_ff >>> FRAC_BITS;
   assign sum     = 35'(org_ff) + 35'($signed(shifted[33:0]));

   always_comb begin
      if (sum > PT_MAX) begin
         pt = 32'sh7FFF_FFFF;
      end else if (sum < PT_MIN) begin
         pt = 32'sh8000_0000;
      end else begin
         pt = sum[31:0];
      end
   end

endmodule

`default_nettype wire

// ----- design/ray_box_slab_intersection_core.sv -----
// -----------------------------------------------------------------------------
// ray_box_slab_intersection_core
// Segment versus axis-aligned box slab test, fixed point, fully pipelined.
// -----------------------------------------------------------------------------
// Stages: input capture, slab dividers, interval merge, entry point, response (Q1.16 default).
// Throughput: one segment per cycle; the six pipelined slab dividers set depth.
// Stall: the whole pipe freezes while the response register holds an untaken
//   result; req ready = response slot free or being taken.
// Reset: synchronous, clears valid bits and box registers (box = all zero).
// -----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersection_core import rbsi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   rbsi_req_if.sink     req_chan,
   rbsi_rsp_if.source   rsp_chan,
   rbsi_csr_if.sink     csr_chan
);

   localparam int Q_W  = FRAC_BITS + 3;          // clamped slab parameter
   localparam int DLAT = FRAC_BITS + 4;          // divider latency
   localparam logic signed [Q_W-1:0] Q_ONE = Q_W'(1 << FRAC_BITS);
   localparam logic signed [Q_W-1:0] Q_TOP = Q_W'((1 << FRAC_BITS) + 1);

   // ---------------------------------------------------------------- box regs
   logic signed [31:0] box_min_ff [NUM_AXES];
   logic signed [31:0] box_max_ff [NUM_AXES];

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            box_min_ff[i] <= '0;
            box_max_ff[i] <= '0;
         end
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_BOX_MIN_X: box_min_ff[0] <= csr_chan.data;
            CSR_BOX_MIN_Y: box_min_ff[1] <= csr_chan.data;
            CSR_BOX_MIN_Z: box_min_ff[2] <= csr_chan.data;
            CSR_BOX_MAX_X: box_max_ff[0] <= csr_chan.data;
            CSR_BOX_MAX_Y: box_max_ff[1] <= csr_chan.data;
            CSR_BOX_MAX_Z: box_max_ff[2] <= csr_chan.data;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // ------------------------------------------------------------ flow control
   logic adv;             // every stage moves one step
   logic rsp_vld_ff;

   assign adv            = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ---------------------------------------------------------- input capture
   logic               s0_vld_ff;
   logic signed [31:0] s0_org_ff [NUM_AXES];
   logic signed [31:0] s0_dlt_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_org_ff[0] <= req_chan.origin_x;
         s0_org_ff[1] <= req_chan.origin_y;
         s0_org_ff[2] <= req_chan.origin_z;
         s0_dlt_ff[0] <= req_chan.delta_x;
         s0_dlt_ff[1] <= req_chan.delta_y;
         s0_dlt_ff[2] <= req_chan.delta_z;
      end
   end

   // ------------------------------------------------- slab dividers per axis
   logic signed [Q_W-1:0] q_min [NUM_AXES];
   logic signed [Q_W-1:0] q_max [NUM_AXES];
   logic [NUM_AXES-1:0]   zero_dlt;   // axis with no motion
   logic [NUM_AXES-1:0]   in_slab;    // origin between the planes

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
      logic signed [32:0] diff_min, diff_max;
      logic [32:0]        mag_min, mag_max;
      logic [31:0]        dlt_mag;

      assign diff_min = 33'(box_min_ff[g]) - 33'(s0_org_ff[g]);
      assign diff_max = 33'(box_max_ff[g]) - 33'(s0_org_ff[g]);
      assign mag_min  = diff_min[32] ? 33'(-diff_min) : diff_min;
      assign mag_max  = diff_max[32] ? 33'(-diff_max) : diff_max;
      assign dlt_mag  = s0_dlt_ff[g][31] ? 32'(-s0_dlt_ff[g]) : s0_dlt_ff[g];

      assign zero_dlt[g] = (s0_dlt_ff[g] == '0);
      assign in_slab[g]  = (box_min_ff[g] <= s0_org_ff[g]) &&
                           (s0_org_ff[g] <= box_max_ff[g]);

      rbsi_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_min (
         .clock   (clock),
         .en      (adv),
         .num_mag (mag_min),
         .den_mag (dlt_mag),
         .neg     (diff_min[32] ^ s0_dlt_ff[g][31]),
         .quot    (q_min[g])
      );

      rbsi_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_max (
         .clock   (clock),
         .en      (adv),
         .num_mag (mag_max),
         .den_mag (dlt_mag),
         .neg     (diff_max[32] ^ s0_dlt_ff[g][31]),
         .quot    (q_max[g])
      );
   end

   // side data rides alongside the dividers
   logic [DLAT-1:0]     sd_vld_ff;
   logic signed [31:0]  sd_org_ff  [DLAT][NUM_AXES];
   logic signed [31:0]  sd_dlt_ff  [DLAT][NUM_AXES];
   logic [NUM_AXES-1:0] sd_zero_ff [DLAT];
   logic [NUM_AXES-1:0] sd_in_ff   [DLAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_vld_ff <= '0;
      end else if (adv) begin
         sd_vld_ff <= {sd_vld_ff[DLAT-2:0], s0_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_org_ff[0]  <= s0_org_ff;
         sd_dlt_ff[0]  <= s0_dlt_ff;
         sd_zero_ff[0] <= zero_dlt;
         sd_in_ff[0]   <= in_slab;
         for (int j = 1; j < DLAT; j++) begin
            sd_org_ff[j]  <= sd_org_ff[j-1];
            sd_dlt_ff[j]  <= sd_dlt_ff[j-1];
            sd_zero_ff[j] <= sd_zero_ff[j-1];
            sd_in_ff[j]   <= sd_in_ff[j-1];
         end
      end
   end

   // ------------------------------------------------- interval intersection
   // Clamped slab values keep every compare exact, so the three axes merge
   // in one step: hit iff all flat axes sit in their slab and lo <= hi.
   logic                  cb_vld_ff;
   logic                  cb_hit_ff, cb_hit_in;
   logic [FRAC_BITS:0]    cb_lo_ff;
   logic signed [Q_W-1:0] cb_lo_in;
   logic signed [31:0]    cb_org_ff [NUM_AXES];
   logic signed [31:0]    cb_dlt_ff [NUM_AXES];

   always_comb begin
      logic signed [Q_W-1:0] t_a, t_b, hi;
      logic                  flat_ok;
      cb_lo_in = '0;
      hi       = Q_ONE;
      flat_ok  = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
         if (sd_zero_ff[DLAT-1][i]) begin
            t_a     = '1;
            t_b     = Q_TOP;
            flat_ok = flat_ok & sd_in_ff[DLAT-1][i];
         end else begin
            t_a = (q_min[i] < q_max[i]) ? q_min[i] : q_max[i];
            t_b = (q_min[i] < q_max[i]) ? q_max[i] : q_min[i];
         end
         if (t_a > cb_lo_in) begin
            cb_lo_in = t_a;
         end
         if (t_b < hi) begin
            hi = t_b;
         end
      end
      cb_hit_in = flat_ok && (cb_lo_in <= hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_vld_ff <= 1'b0;
      end else if (adv) begin
         cb_vld_ff <= sd_vld_ff[DLAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cb_hit_ff <= cb_hit_in;
         cb_lo_ff  <= cb_lo_in[FRAC_BITS:0];
         cb_org_ff <= sd_org_ff[DLAT-1];
         cb_dlt_ff <= sd_dlt_ff[DLAT-1];
      end
   end

   // ------------------------------------------------------------ entry point
   logic               pt_vld_ff;
   logic               pt_hit_ff;
   logic [FRAC_BITS:0] pt_lo_ff;
   logic signed [31:0] pt_val [NUM_AXES];

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_pt
      rbsi_point #(.FRAC_BITS(FRAC_BITS)) u_point (
         .clock (clock),
         .en    (adv),
         .org   (cb_org_ff[g]),
         .dlt   (cb_dlt_ff[g]),
         .lo    (cb_lo_ff),
         .pt    (pt_val[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_vld_ff <= 1'b0;
      end else if (adv) begin
         pt_vld_ff <= cb_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_hit_ff <= cb_hit_ff;
         pt_lo_ff  <= cb_lo_ff;
      end
   end

   // -------------------------------------------------------- response register
   logic               rsp_hit_ff;
   logic [FRAC_BITS:0] rsp_frac_ff;
   logic signed [31:0] rsp_pt_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= pt_vld_ff;
      end
   end

   // miss reports all-zero fields
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff  <= pt_hit_ff;
         rsp_frac_ff <= pt_hit_ff ? pt_lo_ff : '0;
         for (int i = 0; i < NUM_AXES; i++) begin
            rsp_pt_ff[i] <= pt_hit_ff ? pt_val[i] : '0;
         end
      end
   end

   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.hit            = rsp_hit_ff;
   assign rsp_chan.entry_fraction = rsp_frac_ff;
   assign rsp_chan.point_x        = rsp_pt_ff[0];
   assign rsp_chan.point_y        = rsp_pt_ff[1];
   assign rsp_chan.point_z        = rsp_pt_ff[2];

   // -------------------------------------------------------------- assertions
   logic [DLAT+3:0] all_vld;
   assign all_vld = {s0_vld_ff, sd_vld_ff, cb_vld_ff, pt_vld_ff, rsp_vld_ff};

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_hit_ff |-> rsp_frac_ff == '0 && rsp_pt_ff[0] == '0 &&
                                    rsp_pt_ff[1] == '0 && rsp_pt_ff[2] == '0)
      else $error("miss transfer carries nonzero fields");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_hit_ff |-> rsp_frac_ff <= (FRAC_BITS+1)'(1 << FRAC_BITS))
      else $error("entry fraction above 1.0");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(all_vld))
      else $error("pipeline valid bits moved during stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_vld_ff && all_vld == '0)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment versus box slab test core. A predictor
// computes hit, entry fraction and entry point for each request transfer and
// a checker compares every response transfer against the oldest prediction.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rbsi_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam longint ONE_T = longint'(1) << FB;

   typedef struct packed {
      logic               hit;
      logic [FB:0]        frac;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } hit_result_type;

   typedef struct {
      logic signed [31:0] o[3];
      logic signed [31:0] d[3];
   } segment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rbsi_req_if            req_chan ();
   rbsi_rsp_if #(.FRAC_BITS(FB)) rsp_chan ();
   rbsi_csr_if            csr_chan ();

   ray_box_slab_intersection_core #(.FRAC_BITS(FB)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always #10 clock = ~clock;

   // Bench copy of the box corners: [0..2] lower, [3..5] upper.
   logic signed [31:0] box_corner[6];
   hit_result_type     pending_hits[$];
   int                 error_count = 0;
   int                 sent_count  = 0;
   int                 recv_count  = 0;
   int                 hit_count   = 0;
   bit                 hold_rsp    = 1'b0;  // forces the receiver to stall

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic longint floor_scale(longint d, longint t);
      longint p;
      p = d * t;
      if (p >= 0) return p >>> FB;
      return -(((-p) + (ONE_T - 1)) >>> FB);
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic hit_result_type predict_hit(segment_type s);
      hit_result_type r;
      longint lo, hi, a, b, t, bmin, bmax, org, dl;
      bit ok;
      lo = 0;
      hi = ONE_T;
      ok = 1'b1;
      for (int i = 0; i < 3 && ok; i++) begin
         bmin = box_corner[i];
         bmax = box_corner[3+i];
         org  = s.o[i];
         dl   = s.d[i];
         if (dl == 0) begin
            ok = (bmin <= org) && (org <= bmax);
         end else begin
            // SV division of longint truncates toward zero
            a = ((bmin - org) * ONE_T) / dl;
            b = ((bmax - org) * ONE_T) / dl;
            if (a > b) begin
               t = a; a = b; b = t;
            end
            if (b < lo || a > hi) begin
               ok = 1'b0;
            end else begin
               if (a > lo) lo = a;
               if (b < hi) hi = b;
               ok = (lo <= hi);
            end
         end
      end
      r = '0;
      if (ok) begin
         r.hit  = 1'b1;
         r.frac = lo[FB:0];
         r.px   = 32'(sat32(longint'(s.o[0]) + floor_scale(s.d[0], lo)));
         r.py   = 32'(sat32(longint'(s.o[1]) + floor_scale(s.d[1], lo)));
         r.pz   = 32'(sat32(longint'(s.o[2]) + floor_scale(s.d[2], lo)));
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   initial begin
      req_chan.valid = 1'b0;
      req_chan.origin_x = '0; req_chan.origin_y = '0; req_chan.origin_z = '0;
      req_chan.delta_x  = '0; req_chan.delta_y  = '0; req_chan.delta_z  = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data  = '0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // one segment transfer; the prediction is queued on acceptance.
   // valid stays up after the transfer so back to back items need no gap;
   // drain() drops it.
   task automatic send_segment(segment_type s, bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         idle_cycles(gap);
      end
      req_chan.valid    <= 1'b1;
      req_chan.origin_x <= s.o[0];
      req_chan.origin_y <= s.o[1];
      req_chan.origin_z <= s.o[2];
      req_chan.delta_x  <= s.d[0];
      req_chan.delta_y  <= s.d[1];
      req_chan.delta_z  <= s.d[2];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_hits.push_back(predict_hit(s));
      sent_count++;
   endtask

   task automatic write_box(logic [CSR_IDX_W-1:0] idx, logic signed [31:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      box_corner[idx] = val;
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_box(logic signed [31:0] lx, logic signed [31:0] ly,
                          logic signed [31:0] lz, logic signed [31:0] ux,
                          logic signed [31:0] uy, logic signed [31:0] uz);
      write_box(CSR_BOX_MIN_X, lx);
      write_box(CSR_BOX_MIN_Y, ly);
      write_box(CSR_BOX_MIN_Z, lz);
      write_box(CSR_BOX_MAX_X, ux);
      write_box(CSR_BOX_MAX_Y, uy);
      write_box(CSR_BOX_MAX_Z, uz);
   endtask

   // stop sending, wait until every predicted response has been checked
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      idle_cycles(FB + 12);
   endtask

   function automatic segment_type make_seg(logic signed [31:0] ox,
                                            logic signed [31:0] oy,
                                            logic signed [31:0] oz,
                                            logic signed [31:0] dx,
                                            logic signed [31:0] dy,
                                            logic signed [31:0] dz);
      segment_type s;
      s.o[0] = ox; s.o[1] = oy; s.o[2] = oz;
      s.d[0] = dx; s.d[1] = dy; s.d[2] = dz;
      return s;
   endfunction

   // random coordinate: small values near the box most of the time
   function automatic logic signed [31:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      if (r < 7) return 32'sh0;
      if (r < 8) return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
      return $urandom();
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random ready, checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(0, 99) < 75);
   end

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("MISMATCH %s: got %0d expected %0d (response %0d)",
               what, got, want, recv_count);
   endtask

   always @(posedge clock) begin
      hit_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_hits.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = pending_hits.pop_front();
            if (rsp_chan.hit !== want.hit) report_mismatch("hit", rsp_chan.hit, want.hit);
            if (rsp_chan.entry_fraction !== want.frac)
               report_mismatch("entry_fraction", rsp_chan.entry_fraction, want.frac);
            if (rsp_chan.point_x !== want.px) report_mismatch("point_x", rsp_chan.point_x, want.px);
            if (rsp_chan.point_y !== want.py) report_mismatch("point_y", rsp_chan.point_y, want.py);
            if (rsp_chan.point_z !== want.pz) report_mismatch("point_z", rsp_chan.point_z, want.pz);
            if (want.hit) hit_count++;
         end
         recv_count++;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   localparam logic signed [31:0] ONE  = 32'sh0001_0000;
   localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
   localparam logic signed [31:0] MINC = 32'sh8000_0000;

   // reset box (all zero): only segments through the origin point hit
   task automatic test_reset_box();
      send_segment(make_seg(0, 0, 0, 0, 0, 0));
      send_segment(make_seg(ONE, 0, 0, 0, 0, 0));
      send_segment(make_seg(-ONE, 0, 0, 2 * ONE, 0, 0));
      drain();
   endtask

   task automatic test_directed();
      set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
      // crossing through the center, entry at one quarter
      send_segment(make_seg(-2 * ONE, 0, 0, 4 * ONE, 0, 0));
      // reversed direction, needs the swap
      send_segment(make_seg(2 * ONE, 0, 0, -4 * ONE, 0, 0));
      // starting inside the box: entry fraction zero
      send_segment(make_seg(0, 0, 0, ONE, ONE, ONE));
      // ends short of the box
      send_segment(make_seg(-4 * ONE, 0, 0, ONE, 0, 0));
      // zero delta axis outside the slab
      send_segment(make_seg(-2 * ONE, 2 * ONE, 0, 4 * ONE, 0, 0));
      // zero delta axis on the boundary
      send_segment(make_seg(-2 * ONE, ONE, -ONE, 4 * ONE, 0, 0));
      // touching the box at the end point
      send_segment(make_seg(-2 * ONE, 0, 0, ONE, 0, 0));
      // touching a corner diagonally
      send_segment(make_seg(-2 * ONE, -2 * ONE, 0, ONE, ONE, 0));
      // misses by passing the corner
      send_segment(make_seg(-2 * ONE, 0, 0, ONE, 3 * ONE, 0));
      // field extremes, saturating hit point
      send_segment(make_seg(MINC, MINC, MINC, MAXC, MAXC, MAXC));
      send_segment(make_seg(MAXC, MAXC, MAXC, MINC, MINC, MINC));
      send_segment(make_seg(MAXC, 0, 0, MINC, 0, 0));
      send_segment(make_seg(-ONE, 0, 0, MAXC, MINC, 1));
      drain();
      // inverted box: divided axes work, zero delta axes always miss
      set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
      send_segment(make_seg(-2 * ONE, -2 * ONE, -2 * ONE, 4 * ONE, 4 * ONE, 4 * ONE));
      send_segment(make_seg(0, -2 * ONE, -2 * ONE, 0, 4 * ONE, 4 * ONE));
      drain();
      // whole-range box
      set_box(MINC, MINC, MINC, MAXC, MAXC, MAXC);
      send_segment(make_seg(MINC, MAXC, 0, MAXC, MINC, 0));
      send_segment(make_seg(12345, -6789, 1, 0, 0, 0));
      send_segment(make_seg(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
      drain();
      // degenerate box: single point
      set_box(MAXC, MINC, 0, MAXC, MINC, 0);
      send_segment(make_seg(MAXC, MINC, 0, 0, 0, 0));
      send_segment(make_seg(MAXC - 1, MINC, 0, 2, 0, 0));
      drain();
   endtask

   task automatic random_box();
      logic signed [31:0] a, b;
      int r;
      r = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         a = rand_coord();
         b = rand_coord();
         if (r != 0 && a > b) begin
            write_box(3'(i), b);
            write_box(3'(i + 3), a);
         end else begin
            write_box(3'(i), a);
            write_box(3'(i + 3), b);
         end
      end
   endtask

   // random segments, a new random box per phase
   task automatic test_random(int phases, int per_phase);
      segment_type s;
      for (int p = 0; p < phases; p++) begin
         random_box();
         for (int k = 0; k < per_phase; k++) begin
            for (int i = 0; i < 3; i++) begin
               s.o[i] = rand_coord();
               s.d[i] = ($urandom_range(0, 7) == 0) ? 32'sh0 : rand_coord();
            end
            send_segment(s);
         end
         drain();
      end
   endtask

   // receiver stalls for a long time while requests keep coming
   task automatic test_backpressure();
      segment_type s;
      int held;
      set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
      fork
         begin
            hold_rsp = 1'b1;
            held = 0;
            while (held < 200) begin
               @(posedge clock);
               held++;
            end
            hold_rsp = 1'b0;
         end
         for (int k = 0; k < 80; k++) begin
            for (int i = 0; i < 3; i++) begin
               s.o[i] = rand_coord();
               s.d[i] = rand_coord();
            end
            send_segment(s, 1'b1);
         end
      join
      // sender pauses until everything is back
      drain();
   endtask

   initial begin
      for (int i = 0; i < 6; i++) box_corner[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_box();
      test_directed();
      test_backpressure();
      test_random(33, 50);
      $display("Covered %0d segments (%0d hits, %0d misses) over fixed and random boxes,",
               sent_count, hit_count, recv_count - hit_count);
      $display("including zero-delta axes, inverted boxes, saturation and long stalls.");
      if (error_count == 0 && pending_hits.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d responses outstanding", pending_hits.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/rbsi_pkg.sv
design/rbsi_if.sv
design/rbsi_slab_div.sv
design/rbsi_point.sv
design/ray_box_slab_intersection_core.sv
bench/tb_top.sv
